// File: hdl/fbs_pkg.sv
package fbs_pkg;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 8;
    localparam int COLOR_W    = 3;
    localparam int SCAN_ROW_W = 4;
    localparam int COLUMN_W   = 5;
    localparam int CELL_W     = 2 * COLOR_W;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

    localparam logic KIND_SHIFT = 1'b0;
    localparam logic KIND_LATCH = 1'b1;

    typedef struct packed {
        logic we_top;
        logic we_bot;
    } t_mem_ctl;

endpackage

// File: hdl/fbs_store.sv
module fbs_store import fbs_pkg::*; #(
    parameter int SCAN_ROWS = 16,
    parameter int WIDTH     = 32,
    localparam int RW       = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1,
    localparam int CW       = $clog2(WIDTH),
    localparam int AW       = RW + CW,
    localparam int DEPTH    = SCAN_ROWS << CW
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_mem_ctl,
    input  logic [AW-1:0]     i_mem_addr,
    input  logic [COLOR_W-1:0] i_mem_wdata,
    output logic [CELL_W-1:0] o_mem_rdata
);

    // upper and lower halves kept apart so a pixel write needs no read
    logic [COLOR_W-1:0] r_mem_top [0:DEPTH-1];
    logic [COLOR_W-1:0] r_mem_bot [0:DEPTH-1];
    logic [CELL_W-1:0]  r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.we_top) begin
            r_mem_top[i_mem_addr] <= i_mem_wdata;
        end
        if (i_mem_ctl.we_bot) begin
            r_mem_bot[i_mem_addr] <= i_mem_wdata;
        end
        r_rdata <= {r_mem_bot[i_mem_addr], r_mem_top[i_mem_addr]};
    end

    assign o_mem_rdata = r_rdata;

endmodule

// File: hdl/fbs_seq.sv
module fbs_seq import fbs_pkg::*; #(
    parameter int SCAN_ROWS = 16,
    parameter int WIDTH     = 32,
    localparam int RW       = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1,
    localparam int CW       = $clog2(WIDTH),
    localparam int AW       = RW + CW,
    localparam int DEPTH    = SCAN_ROWS << CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [SCAN_ROW_W-1:0] i_scan_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_kind,
    output logic [COLOR_W-1:0]    o_top_rgb,
    output logic [COLOR_W-1:0]    o_bottom_rgb,
    output logic [COLUMN_W-1:0]   o_column,
    output logic [SCAN_ROW_W-1:0] o_row_address,
    output logic                  o_last,
    output t_mem_ctl              o_mem_ctl,
    output logic [AW-1:0]         o_mem_addr,
    output logic [COLOR_W-1:0]    o_mem_wdata,
    input  logic [CELL_W-1:0]     i_mem_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_WRITE,
        S_SCAN_RD,
        S_SCAN_LD,
        S_SCAN_WAIT,
        S_LATCH_WAIT
    } t_state;

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_val, n_val;
    logic                  r_half, n_half;
    logic                  r_is_scan, n_is_scan;
    logic [CW-1:0]         r_col, n_col;
    logic [COLOR_W-1:0]    r_color, n_color;
    logic [SCAN_ROW_W-1:0] r_addr, n_addr;
    logic [AW-1:0]         r_clr, n_clr;
    logic                  r_out_valid, n_out_valid;
    logic                  r_kind, n_kind;
    logic [COLOR_W-1:0]    r_top, n_top;
    logic [COLOR_W-1:0]    r_bot, n_bot;
    logic [COLUMN_W-1:0]   r_column, n_column;
    logic [SCAN_ROW_W-1:0] r_row_addr, n_row_addr;
    logic                  r_last, n_last;

    logic                  w_in_range;
    logic                  w_ge;
    logic [POS_W-1:0]      w_diff;

    // shared compare and subtract unit for the row fold
    assign w_ge   = (r_val >= POS_W'(SCAN_ROWS));
    assign w_diff = r_val - POS_W'(SCAN_ROWS);

    assign w_in_range = (i_pos_x > 8'sd0) && (int'(i_pos_x) < WIDTH - 1) &&
                        (i_pos_y > 8'sd0) && (int'(i_pos_y) < 2 * SCAN_ROWS - 1);

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_half      = r_half;
        n_is_scan   = r_is_scan;
        n_col       = r_col;
        n_color     = r_color;
        n_addr      = r_addr;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_top       = r_top;
        n_bot       = r_bot;
        n_column    = r_column;
        n_row_addr  = r_row_addr;
        n_last      = r_last;
        o_mem_ctl   = '0;
        o_mem_addr  = {r_val[RW-1:0], r_col};
        o_mem_wdata = r_color;
        case (r_state)
            S_CLEAR: begin
                o_mem_ctl.we_top = 1'b1;
                o_mem_ctl.we_bot = 1'b1;
                o_mem_addr       = r_clr;
                o_mem_wdata      = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_WRITE: begin
                            if (w_in_range) begin
                                n_val     = i_pos_y;
                                n_col     = i_pos_x[CW-1:0];
                                n_color   = i_color;
                                n_half    = 1'b0;
                                n_is_scan = 1'b0;
                                n_state   = S_REDUCE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_SCAN: begin
                            n_val     = POS_W'(i_scan_row);
                            n_addr    = i_scan_row;
                            n_col     = '0;
                            n_half    = 1'b0;
                            n_is_scan = 1'b1;
                            n_state   = S_REDUCE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REDUCE: begin
                if (w_ge) begin
                    n_val  = w_diff;
                    n_half = 1'b1;
                end else begin
                    n_state = r_is_scan ? S_SCAN_RD : S_WRITE;
                end
            end
            S_WRITE: begin
                o_mem_ctl.we_top = ~r_half;
                o_mem_ctl.we_bot = r_half;
                n_state          = S_IDLE;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_LD;
            end
            S_SCAN_LD: begin
                n_out_valid = 1'b1;
                n_kind      = KIND_SHIFT;
                n_top       = i_mem_rdata[COLOR_W-1:0];
                n_bot       = i_mem_rdata[CELL_W-1:COLOR_W];
                n_column    = COLUMN_W'(r_col);
                n_row_addr  = '0;
                n_last      = 1'b0;
                n_state     = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                if (!i_out_stall) begin
                    if (r_col == CW'(WIDTH - 1)) begin
                        n_kind     = KIND_LATCH;
                        n_top      = '0;
                        n_bot      = '0;
                        n_column   = '0;
                        n_row_addr = r_addr;
                        n_last     = 1'b1;
                        n_state    = S_LATCH_WAIT;
                    end else begin
                        n_out_valid = 1'b0;
                        n_col       = r_col + 1'b1;
                        n_state     = S_SCAN_RD;
                    end
                end
            end
            S_LATCH_WAIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_val       <= n_val;
            r_half      <= n_half;
            r_is_scan   <= n_is_scan;
            r_col       <= n_col;
            r_color     <= n_color;
            r_addr      <= n_addr;
            r_kind      <= n_kind;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_column    <= n_column;
            r_row_addr  <= n_row_addr;
            r_last      <= n_last;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_top_rgb     = r_top;
    assign o_bottom_rgb  = r_bot;
    assign o_column      = r_column;
    assign o_row_address = r_row_addr;
    assign o_last        = r_last;

endmodule

// File: hdl/led_matrix_frame_buffer_scan_top.sv
// pixel write: row fold in S_REDUCE, then one store write in S_WRITE
// scan: row fold in the shared subtractor, then per column a registered store read
// in S_SCAN_RD and S_SCAN_LD and a beat held until taken, then one latch transaction
// one item at a time: input stalled until the item ends (for a scan, its latch is taken)
// reset: synchronous active low, then a clearing pass, as for a clear command, one store
// entry per cycle over all SCAN_ROWS * 2**clog2(WIDTH) entries, with the input stalled
module led_matrix_frame_buffer_scan_top import fbs_pkg::*; #(
    parameter int SCAN_ROWS = 16,
    parameter int WIDTH     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [SCAN_ROW_W-1:0] i_scan_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_kind,
    output logic [COLOR_W-1:0]    o_top_rgb,
    output logic [COLOR_W-1:0]    o_bottom_rgb,
    output logic [COLUMN_W-1:0]   o_column,
    output logic [SCAN_ROW_W-1:0] o_row_address,
    output logic                  o_last
);

    localparam int RW = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
    localparam int CW = $clog2(WIDTH);
    localparam int AW = RW + CW;

    t_mem_ctl            mem_ctl;
    logic [AW-1:0]       mem_addr;
    logic [COLOR_W-1:0]  mem_wdata;
    logic [CELL_W-1:0]   mem_rdata;

    fbs_seq #(
        .SCAN_ROWS (SCAN_ROWS),
        .WIDTH     (WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_color       (i_color),
        .i_scan_row    (i_scan_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_top_rgb     (o_top_rgb),
        .o_bottom_rgb  (o_bottom_rgb),
        .o_column      (o_column),
        .o_row_address (o_row_address),
        .o_last        (o_last),
        .o_mem_ctl     (mem_ctl),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata)
    );

    fbs_store #(
        .SCAN_ROWS (SCAN_ROWS),
        .WIDTH     (WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_mem_ctl   (mem_ctl),
        .i_mem_addr  (mem_addr),
        .i_mem_wdata (mem_wdata),
        .o_mem_rdata (mem_rdata)
    );

endmodule

// File: bench/led_matrix_frame_buffer_scan_top_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic                           kind;
    logic [fbs_pkg::COLOR_W-1:0]    top_rgb;
    logic [fbs_pkg::COLOR_W-1:0]    bottom_rgb;
    logic [fbs_pkg::COLUMN_W-1:0]   column;
    logic [fbs_pkg::SCAN_ROW_W-1:0] row_address;
    logic                           last;
} t_scan_beat;

class scan_scoreboard #(int ROWS = 16, int COLS = 32);
    logic [fbs_pkg::CELL_W-1:0] frame [ROWS][COLS];
    t_scan_beat pending [$];
    int mismatches;
    int checked;
    int writes_kept;
    int writes_clipped;
    int clears;
    int scans;

    function new();
        wipe_frame();
    endfunction

    function void wipe_frame();
        foreach (frame[r, c]) frame[r][c] = '0;
    endfunction

    function void note_item(logic [fbs_pkg::CMD_W-1:0] cmd,
                            logic signed [fbs_pkg::POS_W-1:0] pos_x,
                            logic signed [fbs_pkg::POS_W-1:0] pos_y,
                            logic [fbs_pkg::COLOR_W-1:0] color,
                            logic [fbs_pkg::SCAN_ROW_W-1:0] scan_row);
        int xi;
        int yi;
        int r;
        t_scan_beat beat;
        xi = pos_x;
        yi = pos_y;
        case (cmd)
            fbs_pkg::CMD_WRITE: begin
                if (xi <= 0 || xi >= COLS - 1 || yi <= 0 || yi >= 2 * ROWS - 1) begin
                    writes_clipped++;
                end else begin
                    r = yi % ROWS;
                    if (yi < ROWS) begin
                        frame[r][xi][fbs_pkg::COLOR_W-1:0] = color;
                    end else begin
                        frame[r][xi][fbs_pkg::CELL_W-1:fbs_pkg::COLOR_W] = color;
                    end
                    writes_kept++;
                end
            end
            fbs_pkg::CMD_CLEAR: begin
                wipe_frame();
                clears++;
            end
            fbs_pkg::CMD_SCAN: begin
                r = int'(scan_row) % ROWS;
                for (int c = 0; c < COLS; c++) begin
                    beat = '0;
                    beat.kind = fbs_pkg::KIND_SHIFT;
                    beat.top_rgb = frame[r][c][fbs_pkg::COLOR_W-1:0];
                    beat.bottom_rgb = frame[r][c][fbs_pkg::CELL_W-1:fbs_pkg::COLOR_W];
                    beat.column = fbs_pkg::COLUMN_W'(c);
                    pending.push_back(beat);
                end
                beat = '0;
                beat.kind = fbs_pkg::KIND_LATCH;
                beat.row_address = scan_row;
                beat.last = 1'b1;
                pending.push_back(beat);
                scans++;
            end
            default: begin
            end
        endcase
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(t_scan_beat got);
        t_scan_beat want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d column %0d",
                                      got.kind, got.column));
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.kind !== want.kind)
            report_mismatch($sformatf("#%0d kind got %0d want %0d",
                                      checked, got.kind, want.kind));
        if (got.top_rgb !== want.top_rgb)
            report_mismatch($sformatf("#%0d top_rgb got %0d want %0d",
                                      checked, got.top_rgb, want.top_rgb));
        if (got.bottom_rgb !== want.bottom_rgb)
            report_mismatch($sformatf("#%0d bottom_rgb got %0d want %0d",
                                      checked, got.bottom_rgb, want.bottom_rgb));
        if (got.column !== want.column)
            report_mismatch($sformatf("#%0d column got %0d want %0d",
                                      checked, got.column, want.column));
        if (got.row_address !== want.row_address)
            report_mismatch($sformatf("#%0d row_address got %0d want %0d",
                                      checked, got.row_address, want.row_address));
        if (got.last !== want.last)
            report_mismatch($sformatf("#%0d last got %0d want %0d",
                                      checked, got.last, want.last));
    endtask
endclass

module led_matrix_frame_buffer_scan_top_tb;
    import fbs_pkg::*;

    localparam int SCAN_ROWS      = 16;
    localparam int WIDTH          = 32;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 200;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 2 * SCAN_ROWS * WIDTH;
    localparam int WATCHDOG_LIMIT = 8000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic                         o_in_stall;
    logic [CMD_W-1:0]             i_cmd        = '0;
    logic signed [POS_W-1:0]      i_pos_x      = '0;
    logic signed [POS_W-1:0]      i_pos_y      = '0;
    logic [COLOR_W-1:0]           i_color      = '0;
    logic [SCAN_ROW_W-1:0]        i_scan_row   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall  = 1'b0;
    logic                         o_kind;
    logic [COLOR_W-1:0]           o_top_rgb;
    logic [COLOR_W-1:0]           o_bottom_rgb;
    logic [COLUMN_W-1:0]          o_column;
    logic [SCAN_ROW_W-1:0]        o_row_address;
    logic                         o_last;

    scan_scoreboard #(SCAN_ROWS, WIDTH) sb;

    bit tx_burst;
    bit rx_quiet;
    bit long_hold_req;
    int idle_cycles;

    led_matrix_frame_buffer_scan_top #(
        .SCAN_ROWS(SCAN_ROWS),
        .WIDTH    (WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_color      (i_color),
        .i_scan_row   (i_scan_row),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_top_rgb    (o_top_rgb),
        .o_bottom_rgb (o_bottom_rgb),
        .o_column     (o_column),
        .o_row_address(o_row_address),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_cmd, i_pos_x, i_pos_y, i_color, i_scan_row);
            if (o_out_valid && !i_out_stall)
                sb.check_result('{o_kind, o_top_rgb, o_bottom_rgb, o_column,
                                  o_row_address, o_last});
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stall per result, one long hold on request
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = rx_quiet ? 0 : $urandom_range(0, 15);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    function automatic logic signed [POS_W-1:0] pick_coord(int span);
        if ($urandom_range(0, 6) == 0) return POS_W'($urandom);
        return POS_W'($urandom_range(0, span - 1));
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [POS_W-1:0] x,
                             logic signed [POS_W-1:0] y, logic [COLOR_W-1:0] color,
                             logic [SCAN_ROW_W-1:0] row);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_color    <= color;
        i_scan_row <= row;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    initial begin
        int n_items;
        int pick;
        bit hold_started;
        bit paused;
        logic [CMD_W-1:0] cmd;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, half boundary, border clipping, unused code, scans
        send_item(CMD_WRITE, 8'sd1, 8'sd1, 3'd1, 4'd0);
        send_item(CMD_WRITE, 8'sd30, 8'sd1, 3'd2, 4'd0);
        send_item(CMD_WRITE, 8'sd1, 8'sd30, 3'd4, 4'd0);
        send_item(CMD_WRITE, 8'sd30, 8'sd30, 3'd7, 4'd0);
        send_item(CMD_WRITE, 8'sd15, 8'sd15, 3'd5, 4'd0);
        send_item(CMD_WRITE, 8'sd15, 8'sd16, 3'd3, 4'd0);
        send_item(CMD_WRITE, 8'sd0, 8'sd5, 3'd7, 4'd0);
        send_item(CMD_WRITE, 8'sd31, 8'sd5, 3'd7, 4'd0);
        send_item(CMD_WRITE, 8'sd5, 8'sd0, 3'd7, 4'd0);
        send_item(CMD_WRITE, 8'sd5, 8'sd31, 3'd7, 4'd0);
        send_item(CMD_WRITE, -8'sd1, 8'sd5, 3'd7, 4'd0);
        send_item(CMD_WRITE, -8'sd128, 8'sd127, 3'd7, 4'd15);
        send_item(CMD_WRITE, 8'sd127, -8'sd128, 3'd7, 4'd15);
        send_item(CMD_UNUSED, 8'sd5, 8'sd5, 3'd7, 4'd1);
        send_item(CMD_SCAN, 8'sd0, 8'sd0, 3'd0, 4'd1);
        send_item(CMD_SCAN, 8'sd0, 8'sd0, 3'd0, 4'd14);
        send_item(CMD_SCAN, -8'sd1, -8'sd1, 3'd7, 4'd15);
        send_item(CMD_SCAN, 8'sd0, 8'sd0, 3'd0, 4'd0);
        send_item(CMD_WRITE, 8'sd20, 8'sd1, 3'd6, 4'd0);
        send_item(CMD_WRITE, 8'sd20, 8'sd17, 3'd1, 4'd0);
        send_item(CMD_SCAN, 8'sd0, 8'sd0, 3'd0, 4'd1);
        send_item(CMD_CLEAR, -8'sd1, -8'sd1, 3'd7, 4'd15);
        send_item(CMD_SCAN, 8'sd0, 8'sd0, 3'd0, 4'd1);
        send_item(CMD_SCAN, 8'sd0, 8'sd0, 3'd0, 4'd14);

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            tx_burst = ((n_items / 32) % 3) == 1;
            rx_quiet = ((n_items / 32) % 3) == 2;
            pick = $urandom_range(0, 99);
            if (pick < 60) cmd = CMD_WRITE;
            else if (pick < 90) cmd = CMD_SCAN;
            else if (pick < 93) cmd = CMD_CLEAR;
            else cmd = CMD_UNUSED;
            // long receiver hold while scans keep coming
            if (n_items >= 60 && n_items < 63) begin
                cmd = CMD_SCAN;
                if (!hold_started) begin
                    hold_started = 1'b1;
                    long_hold_req = 1'b1;
                end
            end
            send_item(cmd, pick_coord(WIDTH), pick_coord(2 * SCAN_ROWS),
                      COLOR_W'($urandom), SCAN_ROW_W'($urandom));
            if (cmd != CMD_UNUSED) n_items++;
            if (n_items == 130 && !paused) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d kept and %0d clipped pixel writes, %0d clears, %0d row scans",
                 sb.writes_kept, sb.writes_clipped, sb.clears, sb.scans);
        $display("%0d output transactions checked, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
